// ----- rtl/fvts_pkg.sv -----
// Shared constants, codes and types for the flat vector top-k search block.
package fvts_pkg;

  localparam int unsigned MAX_VECTORS = 1024;
  localparam int unsigned MAX_DIM     = 128;
  localparam int unsigned MAX_K       = 16;

  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned SCORE_W = 48;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_CW  = $clog2(MAX_DIM + 1);
  localparam int unsigned VEC_W   = $clog2(MAX_VECTORS);
  localparam int unsigned CNT_W   = $clog2(MAX_VECTORS + 1);
  localparam int unsigned VS_AW   = VEC_W + DIM_W;
  localparam int unsigned K_W     = $clog2(MAX_K);
  localparam int unsigned K_CW    = $clog2(MAX_K + 1);

  // Sum of squares, square root and divider widths
  localparam int unsigned SUMSQ_W = 38;
  localparam int unsigned ROOT_W  = 19;
  localparam int unsigned NUM_W   = 30;
  localparam int unsigned QUO_W   = 15;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOPK   = 2'd3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic METRIC_DOT = 1'b0;
  localparam logic METRIC_L2  = 1'b1;

  localparam logic ST_HIT  = 1'b0;
  localparam logic ST_DROP = 1'b1;

  typedef struct packed {
    logic                      clear;
    logic                      ins;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } rank_req_t;

endpackage

// ----- rtl/flat_vector_topk_search.sv -----
// Top level: element gather, unit scaling, vector store and brute-force top-k scan.
//
// Usage: vector elements enter on s_axis, one per transfer; tlast marks the
// final element and tuser says whether the vector is added (0) or queried (1).
// Settings go through the cfg write port while the block is idle.
// Elements are taken one per cycle. After the last element tready drops while:
//   - unit scaling runs (cosine mode with scaling on): a sum of squares over
//     the used elements, a square root, then a divide per used element;
//   - an add copies one full row of MAX_DIM elements into the vector store,
//     one element per cycle through the single store write port;
//   - a query scans stored_count * d elements, one per cycle through the store
//     read port, then drains the pipeline and sends its hits.
// Results leave on m_axis from an output register, best hit first, tlast on
// the final hit; a dropped add gives one transfer with tuser set.
// A stalled m_axis holds the current result; the next hit waits in the list.
// Reset clears control state and restores default settings; memories are not
// cleared and need no sweep, so the block accepts elements right after reset.
module flat_vector_topk_search import fvts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // element [15:0], vector_id [47:16]
  input  logic                  s_axis_tuser,  // opcode
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [79:0]           m_axis_tdata,  // hit_id [31:0], hit_score [79:32]
  output logic                  m_axis_tuser,  // status
  output logic                  m_axis_tlast
);

  localparam logic [3:0] S_GATHER = 4'd0;
  localparam logic [3:0] S_SUMSQ  = 4'd1;
  localparam logic [3:0] S_SQRT   = 4'd2;
  localparam logic [3:0] S_NRD    = 4'd3;
  localparam logic [3:0] S_NDAT   = 4'd4;
  localparam logic [3:0] S_NDIV   = 4'd5;
  localparam logic [3:0] S_DISP   = 4'd6;
  localparam logic [3:0] S_STORE  = 4'd7;
  localparam logic [3:0] S_DROP   = 4'd8;
  localparam logic [3:0] S_SCAN   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  localparam logic [DIM_CW-1:0] DIM_MAX = DIM_CW'(MAX_DIM);
  localparam logic [K_CW-1:0]   K_MAX   = K_CW'(MAX_K);

  // Configuration
  logic              metric_q, norm_en_q;
  logic [7:0]        dim_q;
  logic [4:0]        topk_q;
  logic [DIM_CW-1:0] eff_d;
  logic [K_CW-1:0]   eff_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q  <= METRIC_DOT;
      norm_en_q <= 1'b1;
      dim_q     <= 8'd128;
      topk_q    <= 5'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_METRIC: metric_q  <= cfg_wdata_i[0];
        CFG_NORM:   norm_en_q <= cfg_wdata_i[0];
        CFG_DIM:    dim_q     <= cfg_wdata_i;
        CFG_TOPK:   topk_q    <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_q == '0) eff_d = DIM_CW'(1);
    else if (DIM_CW'(dim_q) > DIM_MAX) eff_d = DIM_MAX;
    else eff_d = DIM_CW'(dim_q);
    if (topk_q == '0) eff_k = K_CW'(1);
    else if (K_CW'(topk_q) > K_MAX) eff_k = K_MAX;
    else eff_k = K_CW'(topk_q);
  end

  // Control and datapath registers
  logic [3:0]                state_q;
  logic [DIM_CW-1:0]         pos_q, used_q, col_q;
  logic [CNT_W-1:0]          cnt_q, row_q;
  logic                      op_q;
  logic [ID_W-1:0]           vid_q;
  logic                      iss_done_q;
  logic                      p1_v_q, p1_first_q, p1_last_q, p1_zero_q;
  logic [DIM_CW-1:0]         p1_col_q;
  logic                      p2_v_q, p2_first_q, p2_last_q;
  logic signed [33:0]        prod_q;
  logic [ID_W-1:0]           p2_id_q;
  logic signed [SCORE_W-1:0] acc_q;
  logic                      sc_v_q;
  logic signed [SCORE_W-1:0] sc_score_q;
  logic [ID_W-1:0]           sc_id_q;
  logic [ROOT_W-1:0]         root_q;
  logic                      sign_q;
  logic [K_CW-1:0]           oidx_q;

  // Memories
  logic signed [ELEM_W-1:0] ebuf_mem [MAX_DIM];
  logic signed [ELEM_W-1:0] vs_mem   [MAX_VECTORS * MAX_DIM];
  logic [ID_W-1:0]          ids_mem  [MAX_VECTORS];
  logic signed [ELEM_W-1:0] eb_rdata_q, vs_rdata_q;
  logic [ID_W-1:0]          ids_rdata_q;
  logic                     eb_we, vs_we, ids_we;
  logic [DIM_W-1:0]         eb_waddr;
  logic signed [ELEM_W-1:0] eb_wdata, vs_wdata;
  logic [VS_AW-1:0]         vs_waddr, vs_raddr;

  // Handshake
  logic              in_fire, out_free;
  logic [DIM_CW-1:0] pos_n, used_n;

  assign s_axis_tready = (state_q == S_GATHER);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign pos_n         = (pos_q < eff_d) ? pos_q + 1'b1 : pos_q;
  assign used_n        = (pos_n < eff_d) ? pos_n : eff_d;

  // Pass issue control (sum of squares, scan, row copy)
  logic              in_pass, iss, st_iss, col_last, pass_idle;
  logic [DIM_CW-1:0] lim;

  assign in_pass   = (state_q == S_SUMSQ) || (state_q == S_SCAN);
  assign iss       = in_pass && !iss_done_q;
  assign st_iss    = (state_q == S_STORE) && (col_q != DIM_MAX);
  assign lim       = (state_q == S_SCAN) ? eff_d : used_q;
  assign col_last  = (col_q + 1'b1 == lim);
  assign pass_idle = iss_done_q && !p1_v_q && !p2_v_q && !sc_v_q;

  // Multiply stage operands
  logic signed [ELEM_W-1:0]  qv;
  logic signed [ELEM_W:0]    qx, vx, df, op_a, op_b;
  logic                      sub;
  logic signed [SCORE_W-1:0] acc_base, prod_x, acc_n;

  assign qv = p1_zero_q ? '0 : eb_rdata_q;
  assign qx = {qv[ELEM_W-1], qv};
  assign vx = {vs_rdata_q[ELEM_W-1], vs_rdata_q};
  assign df = qx - vx;

  always_comb begin
    if (state_q == S_SCAN && metric_q == METRIC_DOT) begin
      op_a = qx;
      op_b = vx;
    end else if (state_q == S_SCAN) begin
      op_a = df;
      op_b = df;
    end else begin
      op_a = qx;
      op_b = qx;
    end
  end

  // Scores stay within 41 bits for any input, so no saturation is needed
  assign sub      = (state_q == S_SCAN) && (metric_q == METRIC_L2);
  assign acc_base = p2_first_q ? '0 : acc_q;
  assign prod_x   = SCORE_W'(prod_q);
  assign acc_n    = sub ? acc_base - prod_x : acc_base + prod_x;

  // Units
  logic                      sq_start, sq_done;
  logic [ROOT_W-1:0]         sq_root;
  logic                      dv_start, dv_done;
  logic [QUO_W-1:0]          dv_quo;
  logic [ELEM_W:0]           mag;
  logic [NUM_W-1:0]          dv_num;
  rank_req_t                 rank_req;
  logic signed [SCORE_W-1:0] rk_score;
  logic [ID_W-1:0]           rk_id;
  logic [K_CW-1:0]           rk_fill;

  assign sq_start = (state_q == S_SUMSQ) && pass_idle && (acc_q != '0);
  assign dv_start = (state_q == S_NDAT);
  assign mag      = eb_rdata_q[ELEM_W-1] ? -{eb_rdata_q[ELEM_W-1], eb_rdata_q}
                                         : {1'b0, eb_rdata_q};
  // Magnitude is at most 2^15, so bit 16 is always clear
  assign dv_num   = {mag[15:0], 14'b0} + NUM_W'(root_q >> 1);

  fvts_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (acc_q[SUMSQ_W-1:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  fvts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (root_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  always_comb begin
    rank_req.clear = (state_q == S_DISP) && (op_q == OP_QUERY);
    rank_req.ins   = sc_v_q;
    rank_req.score = sc_score_q;
    rank_req.id    = sc_id_q;
  end

  fvts_rank u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (rank_req),
    .k_i        (eff_k),
    .rd_idx_i   (oidx_q[K_W-1:0]),
    .rd_score_o (rk_score),
    .rd_id_o    (rk_id),
    .fill_o     (rk_fill)
  );

  // Memory ports
  always_comb begin
    eb_we    = 1'b0;
    eb_waddr = pos_q[DIM_W-1:0];
    eb_wdata = s_axis_tdata[15:0];
    if (in_fire && pos_q < eff_d) begin
      eb_we = 1'b1;
    end else if (state_q == S_NDIV && dv_done) begin
      eb_we    = 1'b1;
      eb_waddr = col_q[DIM_W-1:0];
      eb_wdata = sign_q ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    end
  end

  assign vs_we    = (state_q == S_STORE) && p1_v_q;
  assign vs_waddr = {cnt_q[VEC_W-1:0], p1_col_q[DIM_W-1:0]};
  assign vs_wdata = p1_zero_q ? '0 : eb_rdata_q;
  assign vs_raddr = {row_q[VEC_W-1:0], col_q[DIM_W-1:0]};
  assign ids_we   = (state_q == S_DISP) && (op_q == OP_ADD) &&
                    (cnt_q != CNT_W'(MAX_VECTORS));

  always_ff @(posedge clk_i) begin
    if (eb_we) ebuf_mem[eb_waddr] <= eb_wdata;
    eb_rdata_q <= ebuf_mem[col_q[DIM_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (vs_we) vs_mem[vs_waddr] <= vs_wdata;
    vs_rdata_q <= vs_mem[vs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ids_we) ids_mem[cnt_q[VEC_W-1:0]] <= vid_q;
    ids_rdata_q <= ids_mem[row_q[VEC_W-1:0]];
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    p1_first_q <= (col_q == '0);
    p1_last_q  <= col_last;
    p1_zero_q  <= (col_q >= used_q);
    p1_col_q   <= col_q;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    prod_q     <= op_a * op_b;
    p2_id_q    <= ids_rdata_q;
    sc_score_q <= acc_n;
    sc_id_q    <= p2_id_q;
    if (p2_v_q) acc_q <= acc_n;
    else if (state_q == S_GATHER) acc_q <= '0;
    if (state_q == S_NDAT) sign_q <= eb_rdata_q[ELEM_W-1];
    if (sq_done) root_q <= sq_root;
    if (in_fire && s_axis_tlast) vid_q <= s_axis_tdata[47:16];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_GATHER;
      pos_q      <= '0;
      used_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      cnt_q      <= '0;
      op_q       <= OP_ADD;
      iss_done_q <= 1'b1;
      p1_v_q     <= 1'b0;
      p2_v_q     <= 1'b0;
      sc_v_q     <= 1'b0;
      oidx_q     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      p1_v_q <= iss || st_iss;
      p2_v_q <= p1_v_q && in_pass;
      sc_v_q <= p2_v_q && p2_last_q && (state_q == S_SCAN);
      if (m_axis_tready) m_axis_tvalid <= 1'b0;

      if (iss) begin
        if (col_last) begin
          col_q <= '0;
          if (state_q == S_SCAN) begin
            row_q <= row_q + 1'b1;
            if (row_q + 1'b1 == cnt_q) iss_done_q <= 1'b1;
          end else begin
            iss_done_q <= 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (st_iss) col_q <= col_q + 1'b1;

      case (state_q)
        S_GATHER: begin
          if (in_fire) begin
            pos_q <= pos_n;
            if (s_axis_tlast) begin
              pos_q      <= '0;
              used_q     <= used_n;
              op_q       <= s_axis_tuser;
              col_q      <= '0;
              iss_done_q <= (used_n == '0);
              state_q    <= (norm_en_q && metric_q == METRIC_DOT) ? S_SUMSQ : S_DISP;
            end
          end
        end
        S_SUMSQ: begin
          if (pass_idle) state_q <= (acc_q != '0) ? S_SQRT : S_DISP;
        end
        S_SQRT: begin
          if (sq_done) begin
            col_q   <= '0;
            state_q <= S_NRD;
          end
        end
        S_NRD:  state_q <= S_NDAT;
        S_NDAT: state_q <= S_NDIV;
        S_NDIV: begin
          if (dv_done) begin
            if (col_q + 1'b1 == used_q) begin
              state_q <= S_DISP;
            end else begin
              col_q   <= col_q + 1'b1;
              state_q <= S_NRD;
            end
          end
        end
        S_DISP: begin
          col_q <= '0;
          row_q <= '0;
          if (op_q == OP_ADD) begin
            state_q <= (cnt_q == CNT_W'(MAX_VECTORS)) ? S_DROP : S_STORE;
          end else if (cnt_q == '0) begin
            state_q <= S_GATHER;
          end else begin
            iss_done_q <= 1'b0;
            state_q    <= S_SCAN;
          end
        end
        S_STORE: begin
          if (col_q == DIM_MAX && !p1_v_q) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_GATHER;
          end
        end
        S_DROP: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state_q       <= S_GATHER;
          end
        end
        S_SCAN: begin
          if (pass_idle) begin
            oidx_q  <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            oidx_q        <= oidx_q + 1'b1;
            if (oidx_q + 1'b1 == rk_fill) state_q <= S_GATHER;
          end
        end
        default: state_q <= S_GATHER;
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_DROP && out_free) begin
      m_axis_tdata <= {SCORE_W'(0), vid_q};
      m_axis_tuser <= ST_DROP;
      m_axis_tlast <= 1'b1;
    end else if (state_q == S_EMIT && out_free) begin
      m_axis_tdata <= {rk_score, rk_id};
      m_axis_tuser <= ST_HIT;
      m_axis_tlast <= (oidx_q + 1'b1 == rk_fill);
    end
  end

endmodule

// ----- rtl/fvts_isqrt.sv -----
// Iterative integer square root, two bits of radicand per cycle.
module fvts_isqrt import fvts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUMSQ_W-1:0] x_i,
  output logic               done_o,
  output logic [ROOT_W-1:0]  root_o
);

  logic [SUMSQ_W-1:0] x_q, r_q, bit_q;
  logic               busy_q, done_q;
  logic [SUMSQ_W-1:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= SUMSQ_W'(1) << (SUMSQ_W - 2);
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

// ----- rtl/fvts_div.sv -----
// Restoring divider for unit scaling, one quotient bit per cycle, saturating.
module fvts_div import fvts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int unsigned CNT_DW = $clog2(QUO_W + 1);

  logic [ROOT_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0]  low_q, quo_q;
  logic [CNT_DW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [ROOT_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_q, low_q[QUO_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // Quotient would not fit in 15 bits: finish at once, saturated
        if ({4'b0, num_i[NUM_W-1:QUO_W]} >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_DW'(QUO_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_DW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= {4'b0, num_i[NUM_W-1:QUO_W]};
      low_q <= num_i[QUO_W-1:0];
      quo_q <= '1;
    end else if (busy_q) begin
      rem_q <= fits ? ROOT_W'(shifted - {1'b0, den_q}) : shifted[ROOT_W-1:0];
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/fvts_rank.sv -----
// Sorted list of the best hits, one insertion per cycle.
module fvts_rank import fvts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rank_req_t                 req_i,
  input  logic [K_CW-1:0]           k_i,
  input  logic [K_W-1:0]            rd_idx_i,
  output logic signed [SCORE_W-1:0] rd_score_o,
  output logic [ID_W-1:0]           rd_id_o,
  output logic [K_CW-1:0]           fill_o
);

  logic signed [SCORE_W-1:0] score_q [MAX_K];
  logic [ID_W-1:0]           id_q    [MAX_K];
  logic [K_CW-1:0]           fill_q;
  logic [MAX_K-1:0]          keep;
  logic                      take;

  // Entries at least as good as the new score stay; the mask is a prefix
  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      keep[j] = (K_CW'(j) < fill_q) && (score_q[j] >= req_i.score);
    end
  end

  assign take = req_i.ins && !keep[K_W'(k_i - 1'b1)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (req_i.clear) begin
      fill_q <= '0;
    end else if (take && fill_q < k_i) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int j = 0; j < MAX_K; j++) begin
        if (!keep[j]) begin
          if (j == 0) begin
            score_q[j] <= req_i.score;
            id_q[j]    <= req_i.id;
          end else if (keep[j-1]) begin
            score_q[j] <= req_i.score;
            id_q[j]    <= req_i.id;
          end else begin
            score_q[j] <= score_q[j-1];
            id_q[j]    <= id_q[j-1];
          end
        end
      end
    end
  end

  assign rd_score_o = score_q[rd_idx_i];
  assign rd_id_o    = id_q[rd_idx_i];
  assign fill_o     = fill_q;

endmodule

// ----- rtl/fvts_checker.sv -----
// Port-level checks for the flat vector top-k search block.
module fvts_checker import fvts_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [47:0]           s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [79:0]           m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A dropped add is a single transfer with a zero score
  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_DROP |->
      m_axis_tlast && m_axis_tdata[79:32] == '0)
    else $error("malformed drop result");

  // The last element of a vector starts processing and stops input
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during processing");

  // Hits of one run follow back to back
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a result run");

endmodule

bind flat_vector_topk_search fvts_checker u_fvts_checker (.*);

// ----- tb/sv/flat_vector_topk_search_test.sv -----
// Testbench for the flat vector top-k search block: predicts ranked hits and checks each transfer.
`timescale 1ns / 1ps

module flat_vector_topk_search_test;
  import fvts_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 4000;
  localparam longint SCORE_HI = 64'sd140737488355327;
  localparam longint SCORE_LO = -64'sd140737488355328;

  typedef struct packed {
    logic        status;
    logic [31:0] id;
    logic [47:0] score;
    logic        last;
  } hit_t;

  typedef enum int {FILL_RAND, FILL_SMALL, FILL_ZERO, FILL_MAX, FILL_MIN, FILL_REPEAT} fill_e;

  class hit_predictor;
    logic             metric;
    logic             norm_on;
    logic [7:0]       dim_reg;
    logic [4:0]       k_reg;
    logic signed [15:0] rows[MAX_VECTORS][MAX_DIM];
    logic [31:0]      ids[MAX_VECTORS];
    int               count;
    logic signed [15:0] gather[MAX_DIM];
    int               pos;
    hit_t             hits_due[$];
    int               failures;

    function new();
      metric = METRIC_DOT;
      norm_on = 1'b1;
      dim_reg = 8'd128;
      k_reg = 5'd10;
      count = 0;
      pos = 0;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_METRIC: metric = val[0];
        CFG_NORM:   norm_on = val[0];
        CFG_DIM:    dim_reg = val;
        CFG_TOPK:   k_reg = val[4:0];
        default: ;
      endcase
    endfunction

    function int dim_used();
      if (dim_reg == 0) return 1;
      if (dim_reg > MAX_DIM) return MAX_DIM;
      return int'(dim_reg);
    endfunction

    function int k_used();
      if (k_reg == 0) return 1;
      if (k_reg > MAX_K) return MAX_K;
      return int'(k_reg);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void take_element(logic op, logic signed [15:0] e, logic [31:0] id, logic last);
      int d;
      int kk;
      int p;
      logic signed [15:0] v[MAX_DIM];
      longint sum;
      longint unsigned n, mag, q;
      longint acc, df;
      longint best_s[$];
      logic [31:0] best_i[$];
      hit_t h;
      d = dim_used();
      if (pos < d) begin
        gather[pos] = e;
        pos++;
      end
      if (!last) return;
      for (int i = 0; i < MAX_DIM; i++) v[i] = (i < pos && i < d) ? gather[i] : 16'sd0;
      pos = 0;
      if (norm_on && metric == METRIC_DOT) begin
        sum = 0;
        for (int i = 0; i < d; i++) sum += longint'(v[i]) * longint'(v[i]);
        if (sum != 0) begin
          n = int_sqrt(sum);
          for (int i = 0; i < d; i++) begin
            mag = (v[i] < 0) ? -longint'(v[i]) : longint'(v[i]);
            q = ((mag << 14) + n / 2) / n;
            if (q > 32767) q = 32767;
            v[i] = (v[i] < 0) ? -16'(q) : 16'(q);
          end
        end
      end
      if (op == OP_ADD) begin
        if (count >= MAX_VECTORS) begin
          h = '{status: ST_DROP, id: id, score: '0, last: 1'b1};
          hits_due.push_back(h);
        end else begin
          for (int i = 0; i < MAX_DIM; i++) rows[count][i] = v[i];
          ids[count] = id;
          count++;
        end
        return;
      end
      kk = k_used();
      for (int r = 0; r < count; r++) begin
        acc = 0;
        for (int i = 0; i < d; i++) begin
          if (metric == METRIC_DOT) begin
            acc += longint'(v[i]) * longint'(rows[r][i]);
          end else begin
            df = longint'(v[i]) - longint'(rows[r][i]);
            acc -= df * df;
          end
        end
        if (acc > SCORE_HI) acc = SCORE_HI;
        if (acc < SCORE_LO) acc = SCORE_LO;
        // strictly better moves ahead, so ties keep store order
        p = best_s.size();
        while (p > 0 && acc > best_s[p-1]) p--;
        if (p < kk) begin
          best_s.insert(p, acc);
          best_i.insert(p, ids[r]);
          if (best_s.size() > kk) begin
            void'(best_s.pop_back());
            void'(best_i.pop_back());
          end
        end
      end
      for (int i = 0; i < best_s.size(); i++) begin
        h = '{status: ST_HIT, id: best_i[i], score: best_s[i][47:0],
              last: (i == best_s.size() - 1)};
        hits_due.push_back(h);
      end
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      if (hits_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status %0b id %h score %h last %0b",
                   got.status, got.id, got.score, got.last);
        return;
      end
      want = hits_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected status %0b id %h score %h last %0b, got %0b %h %h %0b",
                   want.status, want.id, want.score, want.last,
                   got.status, got.id, got.score, got.last);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;  // element [15:0], vector_id [47:16]
  logic                  s_axis_tuser = 1'b0;  // opcode
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [79:0]           m_axis_tdata;  // hit_id [31:0], hit_score [79:32]
  logic                  m_axis_tuser;  // status
  logic                  m_axis_tlast;

  flat_vector_topk_search dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hit_predictor pred;
  int cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int items_sent = 0;
  logic signed [15:0] prev_vec[MAX_DIM];

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && pred != null && m_axis_tvalid && m_axis_tready)
      pred.check_hit('{status: m_axis_tuser, id: m_axis_tdata[31:0],
                       score: m_axis_tdata[79:32], last: m_axis_tlast});

  // receiver stall pattern: steady, coin flip, slow toggle, or rare stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 40);
    end
    stall_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= stall_left[2];
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_item(logic op, logic signed [15:0] e, logic [31:0] id, logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {id, e};
    s_axis_tuser <= op;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pred.take_element(op, e, id, last);
    items_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_vector(logic op, int n, logic [31:0] id, fill_e fill);
    logic signed [15:0] e;
    logic o;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_RAND:   e = 16'($urandom);
        FILL_SMALL:  e = 16'($urandom_range(0, 8) - 4) <<< 12;
        FILL_ZERO:   e = '0;
        FILL_MAX:    e = 16'sh7fff;
        FILL_MIN:    e = 16'sh8000;
        default:     e = prev_vec[i % MAX_DIM];
      endcase
      if (i < MAX_DIM) prev_vec[i] = e;
      // only the opcode on the final element matters
      o = (i == n - 1) ? op : logic'($urandom_range(0, 1));
      send_item(o, e, (i == n - 1) ? id : $urandom, i == n - 1);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pred.hits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    pred.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure(logic m, logic nm, logic [7:0] d, logic [7:0] k);
    write_reg(CFG_METRIC, {7'd0, m});
    write_reg(CFG_NORM, {7'd0, nm});
    write_reg(CFG_DIM, d);
    write_reg(CFG_TOPK, k);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int budget);
    int d;
    int n;
    int start;
    fill_e fill;
    start = items_sent;
    d = pred.dim_used();
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1:    n = $urandom_range(1, (d > 1) ? d - 1 : 1);
        2:       n = d + $urandom_range(1, 3);
        default: n = d;
      endcase
      // keep wide vectors short; missing elements read as zero
      if (d > 16) n = $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0, 1:    fill = FILL_RAND;
        2, 3:    fill = FILL_SMALL;
        4:       fill = FILL_REPEAT;
        default: fill = ($urandom_range(0, 3) == 0) ? FILL_ZERO : FILL_SMALL;
      endcase
      send_vector(($urandom_range(0, 9) < 6) ? OP_ADD : OP_QUERY, n, $urandom, fill);
    end
  endtask

  initial begin
    pred = new();
    for (int i = 0; i < MAX_DIM; i++) prev_vec[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: query on empty store, then one short normalized add
    send_vector(OP_QUERY, 2, 32'h1, FILL_RAND);
    send_vector(OP_ADD, 3, 32'h2, FILL_RAND);
    settle();
    configure(METRIC_DOT, 1'b1, 8'd4, 8'd3);
    send_vector(OP_ADD, 4, 32'hffff_ffff, FILL_MAX);
    send_vector(OP_ADD, 4, 32'h0000_0000, FILL_MIN);
    send_vector(OP_ADD, 4, 32'h0000_0003, FILL_ZERO);
    send_vector(OP_ADD, 4, 32'h0000_0004, FILL_REPEAT);
    send_vector(OP_ADD, 2, 32'h0000_0005, FILL_SMALL);
    send_vector(OP_QUERY, 6, 32'h0, FILL_MAX);
    send_vector(OP_QUERY, 4, 32'h0, FILL_ZERO);

    settle();
    configure(METRIC_DOT, 1'b0, 8'd8, 8'd16);
    random_phase(18);
    settle();
    configure(METRIC_L2, 1'b0, 8'd5, 8'd1);
    random_phase(14);
    settle();
    configure(METRIC_L2, 1'b1, 8'd3, 8'd0);
    random_phase(12);
    settle();
    configure(METRIC_DOT, 1'b1, 8'd0, 8'd31);
    random_phase(8);
    settle();
    configure(METRIC_DOT, 1'b0, 8'd200, 8'd5);
    random_phase(10);
    settle();
    configure(METRIC_L2, 1'b0, 8'd255, 8'd16);
    random_phase(10);
    settle();
    configure(METRIC_DOT, 1'b1, 8'd6, 8'd8);
    random_phase(22);

    settle();
    if (pred.failures == 0 && pred.hits_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
